[design/itew_pkg.sv]
// ----------------------------------------------------------------------------
// itew_pkg: shared types and token helpers
// Token codes, the queue entry type and the per-group word functions that
// the front end and the back end both use.
// ----------------------------------------------------------------------------
package itew_pkg;

  localparam int VALUE_W  = 31;
  localparam int CODE_W   = 5;
  localparam int N_DIGITS = 10;
  localparam int BCD_W    = 4 * N_DIGITS;
  localparam int N_GROUPS = 4;
  localparam int N_SLOTS  = 5;
  localparam int NUM_POS  = N_GROUPS * N_SLOTS + 1;
  localparam int ZERO_POS = NUM_POS - 1;

  localparam logic [CODE_W-1:0] TOK_ZERO     = 5'd0;
  localparam logic [CODE_W-1:0] TOK_TENS_OFS = 5'd18;
  localparam logic [CODE_W-1:0] TOK_TEEN_OFS = 5'd10;
  localparam logic [CODE_W-1:0] TOK_HUNDRED  = 5'd28;
  localparam logic [CODE_W-1:0] TOK_THOUSAND = 5'd29;
  localparam logic [CODE_W-1:0] TOK_MILLION  = 5'd30;
  localparam logic [CODE_W-1:0] TOK_BILLION  = 5'd31;

  localparam logic [2:0] SLOT_DIGIT   = 3'd0;
  localparam logic [2:0] SLOT_HUNDRED = 3'd1;
  localparam logic [2:0] SLOT_REST    = 3'd2;
  localparam logic [2:0] SLOT_ONES    = 3'd3;
  localparam logic [2:0] SLOT_SCALE   = 3'd4;

  localparam logic [1:0] GRP_BILLION  = 2'd0;
  localparam logic [1:0] GRP_MILLION  = 2'd1;
  localparam logic [1:0] GRP_THOUSAND = 2'd2;
  localparam logic [1:0] GRP_UNIT     = 2'd3;

  typedef logic [3:0] bcd_t;

  typedef struct packed {
    logic [NUM_POS-1:0] mask;
    logic [BCD_W-1:0]   digits;
  } word_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Which of the five word slots of one group produce a token.
  function automatic logic [N_SLOTS-1:0] group_mask(input bcd_t h, input bcd_t t,
                                                   input bcd_t o, input logic [1:0] g);
    logic [N_SLOTS-1:0] m;
    begin
      m = '0;
      m[SLOT_DIGIT]   = (h != 4'd0);
      m[SLOT_HUNDRED] = (h != 4'd0);
      m[SLOT_REST]    = (t != 4'd0) || (o != 4'd0);
      m[SLOT_ONES]    = (t >= 4'd2) && (o != 4'd0);
      m[SLOT_SCALE]   = (g != GRP_UNIT) && ((h != 4'd0) || (t != 4'd0) || (o != 4'd0));
      return m;
    end
  endfunction

  // The token for one slot of one group.
  function automatic logic [CODE_W-1:0] word_token(input bcd_t h, input bcd_t t,
                                                   input bcd_t o, input logic [1:0] g,
                                                   input logic [2:0] s);
    logic [CODE_W-1:0] tok;
    begin
      case (s)
        SLOT_DIGIT:   tok = CODE_W'(h);
        SLOT_HUNDRED: tok = TOK_HUNDRED;
        SLOT_REST: begin
          if (t >= 4'd2) begin
            tok = CODE_W'(t) + TOK_TENS_OFS;
          end else begin
            tok = CODE_W'(o) + (t[0] ? TOK_TEEN_OFS : TOK_ZERO);
          end
        end
        SLOT_ONES:    tok = CODE_W'(o);
        SLOT_SCALE: begin
          case (g)
            GRP_BILLION:  tok = TOK_BILLION;
            GRP_MILLION:  tok = TOK_MILLION;
            GRP_THOUSAND: tok = TOK_THOUSAND;
            default:      tok = TOK_ZERO;
          endcase
        end
        default:      tok = TOK_ZERO;
      endcase
      return tok;
    end
  endfunction

endpackage

[design/itew_front.sv]
// ----------------------------------------------------------------------------
// itew_front: input stage and decimal conversion
// Accepts a value, converts it to ten decimal digits four bits per cycle,
// works out which word slots are present and pushes the item to the queue.
// ----------------------------------------------------------------------------
module itew_front
  import itew_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [VALUE_W-1:0]   in_value,
  input  q_stat_t              q_stat,
  output logic                 q_push,
  output word_item_t           q_item
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [31:0]      shift_r, shift_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [BCD_W-1:0] bcd_step;
  logic [31:0]      shift_step;
  logic [47:0]      dpad;
  logic [NUM_POS-1:0] mask;

  always_comb begin
    bcd_step   = bcd_r;
    shift_step = shift_r;
    for (int k = 0; k < 4; k++) begin
      for (int d = 0; d < N_DIGITS; d++) begin
        if (bcd_step[4*d +: 4] >= 4'd5) begin
          bcd_step[4*d +: 4] = bcd_step[4*d +: 4] + 4'd3;
        end
      end
      {bcd_step, shift_step} = {bcd_step[BCD_W-2:0], shift_step, 1'b0};
    end
  end

  always_comb begin
    dpad = {8'd0, bcd_r};
    mask = '0;
    for (int g = 0; g < N_GROUPS; g++) begin
      mask[g*N_SLOTS +: N_SLOTS] = group_mask(dpad[4*(3*(3-g)+2) +: 4],
                                              dpad[4*(3*(3-g)+1) +: 4],
                                              dpad[4*(3*(3-g)) +: 4], 2'(g));
    end
    mask[ZERO_POS] = (bcd_r == '0);
  end

  assign in_tready     = (state_r == ST_IDLE);
  assign q_push        = (state_r == ST_PUSH) && !q_stat.full;
  assign q_item.mask   = mask;
  assign q_item.digits = bcd_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    bcd_nxt   = bcd_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          shift_nxt = {1'b0, in_value};
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        shift_nxt = shift_step;
        bcd_nxt   = bcd_step;
        cnt_nxt   = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!q_stat.full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    shift_r <= shift_nxt;
    bcd_r   <= bcd_nxt;
  end

endmodule

[design/itew_queue.sv]
// ----------------------------------------------------------------------------
// itew_queue: two-entry item queue
// Holds converted items between the front end and the word sequencer.
// ----------------------------------------------------------------------------
module itew_queue
  import itew_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  word_item_t push_item,
  input  logic       pop,
  output word_item_t head_item,
  output q_stat_t    stat
);

  word_item_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign head_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[design/itew_back.sv]
// ----------------------------------------------------------------------------
// itew_back: word sequencer
// Steps through the present word slots of one item, one token per cycle when
// not stalled, into a registered output beat, and flags the final token.
// ----------------------------------------------------------------------------
module itew_back
  import itew_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  word_item_t        head_item,
  input  q_stat_t           q_stat,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CODE_W-1:0] out_code,
  output logic              out_last
);

  logic [NUM_POS-1:0] mask_r, mask_nxt;
  logic [BCD_W-1:0]   digits_r;
  logic               out_valid_r;
  logic [CODE_W-1:0]  out_code_r;
  logic               out_last_r;
  logic [NUM_POS-1:0] onehot;
  logic               single;
  logic               emit;
  logic [47:0]        dpad;
  logic [CODE_W-1:0]  tok;

  assign onehot = mask_r & (~mask_r + NUM_POS'(1));
  assign single = ((mask_r & (mask_r - NUM_POS'(1))) == '0);
  assign emit   = (mask_r != '0) && (!out_valid_r || out_tready);
  assign q_pop  = !q_stat.empty && ((mask_r == '0) || (emit && single));

  always_comb begin
    dpad = {8'd0, digits_r};
    tok  = TOK_ZERO;
    for (int g = 0; g < N_GROUPS; g++) begin
      for (int s = 0; s < N_SLOTS; s++) begin
        if (onehot[g*N_SLOTS + s]) begin
          tok = word_token(dpad[4*(3*(3-g)+2) +: 4], dpad[4*(3*(3-g)+1) +: 4],
                           dpad[4*(3*(3-g)) +: 4], 2'(g), 3'(s));
        end
      end
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (q_pop) begin
      mask_nxt = head_item.mask;
    end else if (emit) begin
      mask_nxt = mask_r & ~onehot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (q_pop) begin
      digits_r <= head_item.digits;
    end
    if (emit) begin
      out_code_r <= tok;
      out_last_r <= single;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_code   = out_code_r;
  assign out_last   = out_last_r;

endmodule

[design/integer_to_english_word_tokens_core.sv]
// ----------------------------------------------------------------------------
// integer_to_english_word_tokens_core: number to English word tokens
// Spells a value below 2^31 as a run of word tokens, final token flagged.
//
//   Channel   Direction  Beat contents
//   in_*      input      tdata[30:0] value
//   out_*     output     tdata[4:0] word_code, tlast last_word
//
// The front end accepts a value, converts it four bits at a time, and pushes
// it into a two-entry queue, waiting while the queue is full; it takes no new
// value until that push. The sequencer sends one token per cycle while
// out_tready is high, 1 to 16 per value, and loads the next queued value while
// it sends the final token; the front end works on later values meanwhile.
// Reset is synchronous and empties the queue and the output register.
// ----------------------------------------------------------------------------
module integer_to_english_word_tokens_core
  import itew_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [4:0] word_code
  output logic        out_tlast
);

  q_stat_t           q_stat;
  logic              q_push;
  logic              q_pop;
  word_item_t        q_in_item;
  word_item_t        q_head_item;
  logic [CODE_W-1:0] out_code;

  itew_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_value  (in_tdata[VALUE_W-1:0]),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_item    (q_in_item)
  );

  itew_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .head_item (q_head_item),
    .stat      (q_stat)
  );

  itew_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_item  (q_head_item),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_code   (out_code),
    .out_last   (out_tlast)
  );

  assign out_tdata = {3'd0, out_code};

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full) else $error("push into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty) else $error("pop from an empty queue");

  a_zero_is_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_code == TOK_ZERO) |-> out_tlast)
    else $error("Zero token is not the final token");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("front end ready right after an accept");
`endif

endmodule

[tb/integer_to_english_word_tokens_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_english_word_tokens_core_tb: self-checking bench for the core
// A short table of directed values is followed by random values, most built
// from three-digit groups. Every accepted value is spelled, from its typed words or
// by a local predictor, into a queue of expected word beats, and each output beat
// is checked in order. The sender works in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module integer_to_english_word_tokens_core_tb
  import itew_pkg::*;
();

  localparam int N_RANDOM       = 450;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } word_beat_t;

  typedef struct packed {
    logic [31:0]            data;
    logic [4:0]             n_typed;
    logic [15:0][CODE_W-1:0] typed;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  word_beat_t              expected_words[$];
  logic [CODE_W-1:0]       spelled[$];
  stim_row_t               directed_rows[$];
  int                      typed_n;
  logic [15:0][CODE_W-1:0] typed_words;
  int                      burst_left;
  int                      hold_left;
  int                      cycle_count;
  int                      idle_cycles;
  int                      mismatches;

  integer_to_english_word_tokens_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches = mismatches + 1;
  endtask

  task automatic spell_group(input int grp, input bit with_scale,
                             input logic [CODE_W-1:0] scale);
    int hundreds;
    int rest;
    hundreds = grp / 100;
    rest = grp % 100;
    if (grp == 0) return;
    if (hundreds != 0) begin
      spelled.push_back(CODE_W'(hundreds));
      spelled.push_back(TOK_HUNDRED);
    end
    if (rest != 0 && rest < 20) begin
      spelled.push_back(CODE_W'(rest));
    end else if (rest >= 20) begin
      spelled.push_back(TOK_TENS_OFS + CODE_W'(rest / 10));
      if (rest % 10 != 0) spelled.push_back(CODE_W'(rest % 10));
    end
    if (with_scale) spelled.push_back(scale);
  endtask

  task automatic predict_spelling(input logic [30:0] value);
    int v;
    word_beat_t beat;
    v = int'(value);
    spelled.delete();
    if (v == 0) begin
      spelled.push_back(TOK_ZERO);
    end else begin
      spell_group(v / 1000000000, 1'b1, TOK_BILLION);
      spell_group((v % 1000000000) / 1000000, 1'b1, TOK_MILLION);
      spell_group((v % 1000000) / 1000, 1'b1, TOK_THOUSAND);
      spell_group(v % 1000, 1'b0, TOK_ZERO);
    end
    for (int i = 0; i < spelled.size(); i++) begin
      beat.code = spelled[i];
      beat.last = (i == spelled.size() - 1);
      expected_words.push_back(beat);
    end
  endtask

  function automatic stim_row_t row(input logic [31:0] d, input int n, input logic [79:0] w);
    stim_row_t r;
    r.data = d;
    r.n_typed = n[4:0];
    r.typed = w;
    return r;
  endfunction

  function automatic int rand_group();
    case ($urandom_range(0, 7))
      0, 1:    return 0;
      2:       return $urandom_range(1, 19);
      3:       return 10 * $urandom_range(2, 9);
      4:       return 100 * $urandom_range(1, 9);
      5:       return 100 * $urandom_range(1, 9) + $urandom_range(1, 19);
      default: return $urandom_range(0, 999);
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    logic [63:0] v;
    logic        hi;
    int          b;
    int          m;
    hi = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0) return $urandom;
    b = $urandom_range(0, 2);
    m = rand_group();
    if (b == 2) m = m % 147;
    v = b * 64'd1000000000 + m * 64'd1000000 + rand_group() * 64'd1000 + rand_group();
    return {hi, v[30:0]};
  endfunction

  task automatic send_value(input logic [31:0] d, input int n, input logic [79:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left = burst_left - 1;
    in_tdata <= d;
    typed_n = n;
    typed_words = w;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Receiver: runs of ready and stall of random length, with free-running stretches.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (cycle_count % 3000 < 600) begin
      out_tready <= 1'b1;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      hold_left <= $urandom_range(0, 8);
    end else begin
      out_tready <= 1'b1;
      hold_left <= $urandom_range(0, 20);
    end
  end

  always @(posedge clk) begin
    word_beat_t want;
    cycle_count = cycle_count + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (typed_n != 0) begin
          for (int i = 0; i < typed_n; i++) begin
            want.code = typed_words[typed_n - 1 - i];
            want.last = (i == typed_n - 1);
            expected_words.push_back(want);
          end
        end else begin
          predict_spelling(in_tdata[30:0]);
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected beat code %0d last %0b",
                                    out_tdata[4:0], out_tlast));
        end else begin
          want = expected_words.pop_front();
          if (out_tdata[4:0] != want.code)
            report_mismatch($sformatf("word_code %0d, predicted %0d",
                                      out_tdata[4:0], want.code));
          if (out_tlast != want.last)
            report_mismatch($sformatf("last_word %0b, predicted %0b", out_tlast, want.last));
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    typed_n = 0;
    typed_words = '0;
    burst_left = 0;
    hold_left = 0;
    cycle_count = 0;
    idle_cycles = 0;
    mismatches = 0;

    directed_rows.push_back(row(32'd0, 1, {TOK_ZERO}));
    directed_rows.push_back(row(32'd1, 1, {5'd1}));
    directed_rows.push_back(row(32'h7FFF_FFFF, 16,
      {5'd2, TOK_BILLION, 5'd1, TOK_HUNDRED, 5'd22, 5'd7, TOK_MILLION,
       5'd4, TOK_HUNDRED, 5'd26, 5'd3, TOK_THOUSAND, 5'd6, TOK_HUNDRED, 5'd22, 5'd7}));
    directed_rows.push_back(row(32'd1000000000, 2, {5'd1, TOK_BILLION}));
    directed_rows.push_back(row(32'h8000_0000, 1, {TOK_ZERO}));
    directed_rows.push_back(row(32'hFFFF_FFFF, 16,
      {5'd2, TOK_BILLION, 5'd1, TOK_HUNDRED, 5'd22, 5'd7, TOK_MILLION,
       5'd4, TOK_HUNDRED, 5'd26, 5'd3, TOK_THOUSAND, 5'd6, TOK_HUNDRED, 5'd22, 5'd7}));
    directed_rows.push_back(row(32'd10, 0, '0));
    directed_rows.push_back(row(32'd11, 0, '0));
    directed_rows.push_back(row(32'd19, 0, '0));
    directed_rows.push_back(row(32'd20, 0, '0));
    directed_rows.push_back(row(32'd21, 0, '0));
    directed_rows.push_back(row(32'd99, 0, '0));
    directed_rows.push_back(row(32'd100, 0, '0));
    directed_rows.push_back(row(32'd101, 0, '0));
    directed_rows.push_back(row(32'd110, 0, '0));
    directed_rows.push_back(row(32'd999, 0, '0));
    directed_rows.push_back(row(32'd1000, 0, '0));
    directed_rows.push_back(row(32'd1000000, 0, '0));
    directed_rows.push_back(row(32'd1001001, 0, '0));
    directed_rows.push_back(row(32'd1000000001, 0, '0));
    directed_rows.push_back(row(32'd2000000000, 0, '0));
    directed_rows.push_back(row(32'd1100000000, 0, '0));
    directed_rows.push_back(row(32'd12345678, 0, '0));
    directed_rows.push_back(row(32'd900000019, 0, '0));
    directed_rows.push_back(row(32'h8000_0000 | 32'd777777, 0, '0));

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      send_value(directed_rows[i].data, directed_rows[i].n_typed, directed_rows[i].typed);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      send_value(rand_value(), 0, '0);
    end
    in_tvalid <= 1'b0;

    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
design/itew_pkg.sv
design/itew_front.sv
design/itew_queue.sv
design/itew_back.sv
design/integer_to_english_word_tokens_core.sv
tb/integer_to_english_word_tokens_core_tb.sv
